// ===== design/iis_pkg.sv =====
// iis_pkg: shared types and constants for the integral image unit
// used by iis_front, iis_back, the top and the channel interfaces
package iis_pkg;

	localparam int PIX_W      = 8;
	localparam int INT_W      = 28;
	localparam int SQ_W       = 36;
	localparam int ROW_CFG_W  = 11;
	localparam int FRM_CFG_W  = 21;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 21;
	localparam int STATUS_W   = 2;
	localparam int CMP_W      = 32;

	localparam int DEF_MAX_ROW_WIDTH = 1024;
	localparam int DEF_MAX_ROWS      = 1024;

	localparam logic [ROW_CFG_W-1:0] ROW_WIDTH_RST    = 11'd640;
	localparam logic [FRM_CFG_W-1:0] FRAME_PIXELS_RST = 21'd307200;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 8'd1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 2'd0,
		ST_ZERO_DIM    = 2'd1,
		ST_FRAME_SHORT = 2'd2,
		ST_TOO_LARGE   = 2'd3
	} iis_status_t;

	// one transaction between the front stage and the output stage
	typedef struct packed {
		iis_status_t            status;
		logic                   use_above;
		logic                   last;
		logic [INT_W-1:0]       row_sum;
		logic [SQ_W-1:0]        row_sq_sum;
	} iis_s1_t;

endpackage

// ===== design/iis_if.sv =====
// iis_if: valid/ready channel interfaces for pixels and results
// depends on iis_pkg for field widths
interface iis_pix_if import iis_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

interface iis_res_if import iis_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [INT_W-1:0]    integral_sum;
	logic [SQ_W-1:0]     square_sum;
	logic                frame_end;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output integral_sum, output square_sum,
		output frame_end, output status, input ready);
	modport sink (input valid, input integral_sum, input square_sum,
		input frame_end, input status, output ready);
endinterface

// ===== design/iis_line_mem.sv =====
// iis_line_mem: one-row line store, one write and one registered read port
// a read at the address being written in the same cycle returns the new data
module iis_line_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 28
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/iis_front.sv =====
// iis_front: configuration registers, status check, raster counters, row sums
// loads the first pipeline register and issues line store reads; uses iis_pkg
module iis_front import iis_pkg::*; #(
	parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
	parameter int MAX_ROWS      = DEF_MAX_ROWS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [CFG_IDX_W-1:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]            cfg_wdata,
	iis_pix_if.sink                          pix,
	input  logic                             adv,
	output logic                             valid_s1,
	output iis_s1_t                          data_s1,
	output logic [$clog2(MAX_ROW_WIDTH)-1:0] col_s1,
	output logic                             rd_en,
	output logic [$clog2(MAX_ROW_WIDTH)-1:0] rd_addr
);

	localparam int COL_W   = $clog2(MAX_ROW_WIDTH);
	localparam int PIXI_W  = $clog2(MAX_ROW_WIDTH * MAX_ROWS);
	localparam int ROW_W   = $clog2(MAX_ROW_WIDTH * 255 + 1);
	localparam int ROWSQ_W = $clog2(MAX_ROW_WIDTH * 65025 + 1);
	localparam logic [CMP_W-1:0] MAX_RW_C  = CMP_W'(MAX_ROW_WIDTH);
	localparam logic [CMP_W-1:0] MAX_PIX_C = CMP_W'(MAX_ROW_WIDTH * MAX_ROWS);

	logic [ROW_CFG_W-1:0] row_width_q;
	logic [FRM_CFG_W-1:0] frame_pixels_q;
	logic [COL_W-1:0]     col_q;
	logic [PIXI_W-1:0]    pixel_q;
	logic [ROW_W-1:0]     row_sum_q;
	logic [ROWSQ_W-1:0]   row_sq_q;
	logic                 valid_q;

	logic [CMP_W-1:0]   rw_c, fp_c, pix_c, pix_nx_c, col_nx_c;
	iis_status_t        status_w;
	logic               accept, ok_w, last_w, wrap_w, use_above_w;
	logic [15:0]        sq_w;
	logic [ROW_W-1:0]   row_sum_nx;
	logic [ROWSQ_W-1:0] row_sq_nx;

	assign rw_c     = CMP_W'(row_width_q);
	assign fp_c     = CMP_W'(frame_pixels_q);
	assign pix_c    = CMP_W'(pixel_q);
	assign pix_nx_c = pix_c + CMP_W'(1);
	assign col_nx_c = CMP_W'(col_q) + CMP_W'(1);

	always_comb begin
		if ((rw_c == '0) || (fp_c == '0)) begin
			status_w = ST_ZERO_DIM;
		end else if (fp_c < rw_c) begin
			status_w = ST_FRAME_SHORT;
		end else if ((rw_c > MAX_RW_C) || (fp_c > MAX_PIX_C)) begin
			status_w = ST_TOO_LARGE;
		end else begin
			status_w = ST_OK;
		end
	end

	assign ok_w        = (status_w == ST_OK);
	assign pix.ready   = !valid_q || adv;
	assign accept      = pix.valid && pix.ready;
	assign sq_w        = {8'd0, pix.pixel_value} * {8'd0, pix.pixel_value};
	assign row_sum_nx  = row_sum_q + ROW_W'(pix.pixel_value);
	assign row_sq_nx   = row_sq_q + ROWSQ_W'(sq_w);
	assign use_above_w = (pix_c >= rw_c);
	assign last_w      = (pix_nx_c >= fp_c);
	assign wrap_w      = (col_nx_c >= rw_c);

	assign rd_en   = accept && ok_w;
	assign rd_addr = col_q;

	// configuration and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q    <= ROW_WIDTH_RST;
			frame_pixels_q <= FRAME_PIXELS_RST;
			col_q          <= '0;
			pixel_q        <= '0;
			row_sum_q      <= '0;
			row_sq_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_WIDTH: begin
					row_width_q <= cfg_wdata[ROW_CFG_W-1:0];
					col_q       <= '0;
					pixel_q     <= '0;
					row_sum_q   <= '0;
					row_sq_q    <= '0;
				end
				REG_FRAME_PIXELS: begin
					frame_pixels_q <= cfg_wdata[FRM_CFG_W-1:0];
					col_q          <= '0;
					pixel_q        <= '0;
					row_sum_q      <= '0;
					row_sq_q       <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept && ok_w) begin
			if (last_w) begin
				col_q     <= '0;
				pixel_q   <= '0;
				row_sum_q <= '0;
				row_sq_q  <= '0;
			end else begin
				pixel_q <= pixel_q + PIXI_W'(1);
				if (wrap_w) begin
					col_q     <= '0;
					row_sum_q <= '0;
					row_sq_q  <= '0;
				end else begin
					col_q     <= col_q + COL_W'(1);
					row_sum_q <= row_sum_nx;
					row_sq_q  <= row_sq_nx;
				end
			end
		end
	end

	// first pipeline register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pix.ready) begin
			valid_q <= pix.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1.status     <= status_w;
			data_s1.use_above  <= ok_w && use_above_w;
			data_s1.last       <= ok_w && last_w;
			data_s1.row_sum    <= ok_w ? INT_W'(row_sum_nx) : '0;
			data_s1.row_sq_sum <= ok_w ? SQ_W'(row_sq_nx) : '0;
			col_s1             <= col_q;
		end
	end

	assign valid_s1 = valid_q;

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		ok_w |-> (CMP_W'(col_q) < rw_c))
		else $error("column index past row width");

	a_col_le_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(col_q) <= pix_c)
		else $error("column index ahead of pixel index");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ok_w && last_w && !cfg_we) |=> (pixel_q == '0 && col_q == '0))
		else $error("counters not restarted after frame end");

endmodule

// ===== design/iis_back.sv =====
// iis_back: adds the stored value above, writes the line stores, holds the result
// output register of the unit; uses iis_pkg and the result interface
module iis_back import iis_pkg::*; #(
	parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             valid_s1,
	input  iis_s1_t                          data_s1,
	input  logic [$clog2(MAX_ROW_WIDTH)-1:0] col_s1,
	input  logic [INT_W-1:0]                 above_int,
	input  logic [SQ_W-1:0]                  above_sq,
	output logic                             adv,
	output logic                             wr_en,
	output logic [$clog2(MAX_ROW_WIDTH)-1:0] wr_addr,
	output logic [INT_W-1:0]                 wr_int,
	output logic [SQ_W-1:0]                  wr_sq,
	iis_res_if.source                        res
);

	logic                out_valid_q;
	logic [INT_W-1:0]    isum_q;
	logic [SQ_W-1:0]     ssum_q;
	logic                last_q;
	logic [STATUS_W-1:0] status_q;
	logic [INT_W-1:0]    isum_w;
	logic [SQ_W-1:0]     ssum_w;

	assign adv    = valid_s1 && (!out_valid_q || res.ready);
	assign isum_w = data_s1.row_sum + (data_s1.use_above ? above_int : '0);
	assign ssum_w = data_s1.row_sq_sum + (data_s1.use_above ? above_sq : '0);

	assign wr_en   = adv && (data_s1.status == ST_OK);
	assign wr_addr = col_s1;
	assign wr_int  = isum_w;
	assign wr_sq   = ssum_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			isum_q   <= isum_w;
			ssum_q   <= ssum_w;
			last_q   <= data_s1.last;
			status_q <= data_s1.status;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.integral_sum = isum_q;
	assign res.square_sum   = ssum_q;
	assign res.frame_end    = last_q;
	assign res.status       = status_q;

	a_bad_cfg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK) |->
		(isum_q == '0 && ssum_q == '0 && !last_q))
		else $error("nonzero result with invalid configuration");

endmodule

// ===== design/integral_image_with_squares_unit.sv =====
// integral_image_with_squares_unit: streaming integral image and squared integral
// top level; depends on iis_pkg, iis_if, iis_front, iis_line_mem, iis_back
//
// Pixels arrive in raster order on pix and one result leaves on res for every
// pixel: the summed-area value, the summed-area value of squared pixels, a
// frame end flag on the last pixel of a frame, and a status code. The unit
// takes one pixel per clock while res accepts results; each result passes through
// the first pipeline register and then the output register, which lets the next
// pixel in while a result waits.
// The rate is set by the read-modify-write of the two line stores (one entry
// per column, MAX_ROW_WIDTH deep), whose same-cycle write is forwarded to the
// read so rows of any width down to one pixel run at full rate. Line stores
// need no clearing after reset: the first row of each frame writes a column
// before any later row reads it. Writing either register restarts the frame.
// A zero size, fewer frame pixels than row pixels, or a size beyond the line
// stores or MAX_ROW_WIDTH * MAX_ROWS pixels gives zero sums and a nonzero status.
module integral_image_with_squares_unit import iis_pkg::*; #(
	parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
	parameter int MAX_ROWS      = DEF_MAX_ROWS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	iis_pix_if.sink               pix,
	iis_res_if.source             res
);

	localparam int COL_W = $clog2(MAX_ROW_WIDTH);

	logic             valid_s1, adv, rd_en, wr_en;
	iis_s1_t          data_s1;
	logic [COL_W-1:0] col_s1, rd_addr, wr_addr;
	logic [INT_W-1:0] above_int, wr_int;
	logic [SQ_W-1:0]  above_sq, wr_sq;

	iis_front #(
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH),
		.MAX_ROWS      (MAX_ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix       (pix),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.col_s1    (col_s1),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr)
	);

	iis_line_mem #(
		.DEPTH (MAX_ROW_WIDTH),
		.WIDTH (INT_W)
	) u_above_int (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_int),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (above_int)
	);

	iis_line_mem #(
		.DEPTH (MAX_ROW_WIDTH),
		.WIDTH (SQ_W)
	) u_above_sq (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_sq),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (above_sq)
	);

	iis_back #(
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1),
		.col_s1    (col_s1),
		.above_int (above_int),
		.above_sq  (above_sq),
		.adv       (adv),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_int    (wr_int),
		.wr_sq     (wr_sq),
		.res       (res)
	);

endmodule

// ===== test/iis_sum_checker.sv =====
// iis_sum_checker: predicts the integral and squared-integral result of every pixel
// transaction and compares it with the result transactions of the unit
// depends on iis_pkg and the channel interfaces in iis_if
`timescale 1ns / 100ps

module iis_sum_checker import iis_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	iis_pix_if                    pix,
	iis_res_if                    res,
	output int unsigned           outstanding,
	output int unsigned           fail_count
);

	localparam int     LINE_DEPTH = DEF_MAX_ROW_WIDTH;
	localparam int     COL_W      = $clog2(DEF_MAX_ROW_WIDTH);
	localparam int     PIX_IDX_W  = 20;
	localparam longint MAX_FRAME  = longint'(DEF_MAX_ROW_WIDTH) * DEF_MAX_ROWS;

	typedef struct packed {
		logic [INT_W-1:0] integral_sum;
		logic [SQ_W-1:0]  square_sum;
		logic             frame_end;
		iis_status_t      status;
	} iis_sums_t;

	logic [ROW_CFG_W-1:0] row_width;
	logic [FRM_CFG_W-1:0] frame_pixels;
	logic [INT_W:0]       above_sum [LINE_DEPTH];
	logic [SQ_W:0]        above_sq [LINE_DEPTH];
	logic [17:0]          row_sum;
	logic [25:0]          row_sq;
	logic [COL_W-1:0]     col_idx;
	logic [PIX_IDX_W-1:0] pix_idx;
	iis_sums_t            expected_sums [$];

	function automatic void restart_frame();
		row_sum = '0;
		row_sq  = '0;
		col_idx = '0;
		pix_idx = '0;
	endfunction

	function automatic iis_status_t config_status();
		if (row_width == 0 || frame_pixels == 0)
			return ST_ZERO_DIM;
		if (frame_pixels < row_width)
			return ST_FRAME_SHORT;
		if (row_width > DEF_MAX_ROW_WIDTH || longint'(frame_pixels) > MAX_FRAME)
			return ST_TOO_LARGE;
		return ST_OK;
	endfunction

	function automatic iis_sums_t predict_sums(input logic [PIX_W-1:0] p);
		iis_sums_t        r;
		logic [INT_W:0]   isum;
		logic [SQ_W:0]    ssum;
		logic [COL_W-1:0] col;
		logic             last;
		r = '0;
		r.status = config_status();
		if (r.status != ST_OK)
			return r;
		col = col_idx;
		row_sum = row_sum + p;
		row_sq = row_sq + p * p;
		isum = row_sum;
		ssum = row_sq;
		if (pix_idx >= row_width) begin
			isum = isum + above_sum[col];
			ssum = ssum + above_sq[col];
		end
		above_sum[col] = isum;
		above_sq[col] = ssum;
		last = (pix_idx + 1 >= frame_pixels);
		if (last) begin
			restart_frame();
		end else begin
			pix_idx = pix_idx + 1'b1;
			if (col_idx + 1 >= row_width) begin
				col_idx = '0;
				row_sum = '0;
				row_sq = '0;
			end else begin
				col_idx = col_idx + 1'b1;
			end
		end
		r.integral_sum = isum[INT_W-1:0];
		r.square_sum = ssum[SQ_W-1:0];
		r.frame_end = last;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [63:0] want_v,
		input logic [63:0] got_v);
		if (got_v !== want_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		iis_sums_t want;
		if (!arst_n) begin
			row_width = ROW_WIDTH_RST;
			frame_pixels = FRAME_PIXELS_RST;
			restart_frame();
			expected_sums.delete();
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROW_WIDTH: begin
						row_width = cfg_wdata[ROW_CFG_W-1:0];
						restart_frame();
					end
					REG_FRAME_PIXELS: begin
						frame_pixels = cfg_wdata[FRM_CFG_W-1:0];
						restart_frame();
					end
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (expected_sums.size() == 0) begin
					$error("result transaction with nothing expected: integral_sum %0d",
						res.integral_sum);
					fail_count++;
				end else begin
					want = expected_sums.pop_front();
					check_field("integral_sum", want.integral_sum, res.integral_sum);
					check_field("square_sum", want.square_sum, res.square_sum);
					check_field("frame_end", want.frame_end, res.frame_end);
					check_field("status", want.status, res.status);
				end
			end
			if (pix.valid && pix.ready)
				expected_sums.push_back(predict_sums(pix.pixel_value));
			outstanding = expected_sums.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// tb_top: drives pixel and configuration traffic into integral_image_with_squares_unit
// and gives the verdict; prediction and comparison live in iis_sum_checker
// depends on iis_pkg, iis_if, iis_sum_checker and the unit itself
`timescale 1ns / 100ps

module tb_top;
	import iis_pkg::*;

	localparam int TOTAL_ITEMS   = 1700;
	localparam int IDLE_PCT      = 25;
	localparam int HOLD_CYCLES   = 64;
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 2000;
	localparam int STEADY_ITEMS  = 200;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

	typedef enum {PAT_RANDOM, PAT_EXTREME, PAT_MAX, PAT_ZERO} pix_pattern_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int unsigned           outstanding;
	int unsigned           fail_count;
	int unsigned           items_sent;
	int unsigned           hold_requests;
	bit                    steady_tx;
	bit                    steady_rx;

	iis_pix_if pix_ch();
	iis_res_if res_ch();

	integral_image_with_squares_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pix       (pix_ch),
		.res       (res_ch)
	);

	iis_sum_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.pix         (pix_ch),
		.res         (res_ch),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [PIX_W-1:0] next_pixel(input pix_pattern_t pat);
		case (pat)
			PAT_MAX:     return 8'hFF;
			PAT_ZERO:    return 8'h00;
			PAT_EXTREME: return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
			default:     return PIX_W'($urandom_range(255));
		endcase
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] value);
		while (!steady_tx && $urandom_range(99) < IDLE_PCT) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_value <= value;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		items_sent++;
	endtask

	task automatic wait_drained();
		pix_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_frame(input logic [CFG_DATA_W-1:0] row_data,
		input logic [CFG_DATA_W-1:0] frame_data, input bit poke_unused);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROW_WIDTH;
		cfg_wdata <= row_data;
		@(posedge clk);
		cfg_index <= REG_FRAME_PIXELS;
		cfg_wdata <= frame_data;
		@(posedge clk);
		if (poke_unused) begin
			cfg_index <= REG_UNUSED + CFG_IDX_W'($urandom_range(253));
			cfg_wdata <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int row_i, input int frame_i, input int count,
		input pix_pattern_t pat, input bit poke_unused, input bit hold);
		program_frame(CFG_DATA_W'(row_i), CFG_DATA_W'(frame_i), poke_unused);
		if (hold)
			hold_requests++;
		repeat (count) send_pixel(next_pixel(pat));
		wait_drained();
	endtask

	initial begin : receiver
		int          hold_left;
		int unsigned hold_served;
		hold_left = 0;
		hold_served = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_served) begin
				hold_served = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= steady_rx || $urandom_range(99) >= IDLE_PCT;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("integral_image_with_squares_unit test failed");
		$finish;
	end

	initial begin : stimulus
		int           phase;
		int           kind;
		int           row_i;
		int           frame_i;
		int           count;
		int           pick;
		pix_pattern_t pat;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROW_WIDTH;
		cfg_wdata = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_value = '0;
		items_sent = 0;
		hold_requests = 0;
		steady_tx = 1'b0;
		steady_rx = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset configuration
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h80);
		wait_drained();
		// one-pixel frames, then one-column rows
		run_phase(1, 1, 2, PAT_MAX, 1'b0, 1'b0);
		run_phase(1, 3, 3, PAT_MAX, 1'b0, 1'b0);
		// partial last row, then into the next frame
		run_phase(3, 7, 8, PAT_MAX, 1'b1, 1'b0);
		// bad configurations
		run_phase(0, 5, 1, PAT_MAX, 1'b0, 1'b0);
		run_phase(4, 0, 1, PAT_MAX, 1'b0, 1'b0);
		run_phase(5, 4, 1, PAT_MAX, 1'b0, 1'b0);
		run_phase(16, 1048577, 1, PAT_MAX, 1'b0, 1'b0);
		run_phase(2047, 2097151, 1, PAT_MAX, 1'b0, 1'b0);
		// largest legal frame, then row width with bits above the register
		run_phase(1024, 1048576, 2, PAT_MAX, 1'b0, 1'b0);
		run_phase(21'h1FF804, 8, 2, PAT_MAX, 1'b1, 1'b0);

		phase = 0;
		while (items_sent < TOTAL_ITEMS) begin
			kind = $urandom_range(99);
			pick = $urandom_range(19);
			pat = (pick == 0) ? PAT_ZERO : (pick == 1) ? PAT_MAX :
				(pick < 5) ? PAT_EXTREME : PAT_RANDOM;
			steady_tx = (phase == 1);
			steady_rx = (phase == 1);
			if (kind < 8 && phase > 3) begin
				count = $urandom_range(1, 4);
				case ($urandom_range(3))
					0: begin
						row_i = 0;
						frame_i = $urandom_range(2097151);
					end
					1: begin
						row_i = $urandom_range(2047);
						frame_i = 0;
					end
					2: begin
						row_i = $urandom_range(2, 1024);
						frame_i = $urandom_range(1, row_i - 1);
					end
					default: begin
						if ($urandom_range(1) != 0) begin
							row_i = $urandom_range(1025, 2047);
							frame_i = $urandom_range(row_i, 2097151);
						end else begin
							row_i = $urandom_range(1, 1024);
							frame_i = $urandom_range(1048577, 2097151);
						end
					end
				endcase
			end else if (kind < 14 && phase > 3) begin
				row_i = $urandom_range(513, 1024);
				frame_i = row_i + $urandom_range(1048576 - row_i);
				count = $urandom_range(10, 40);
			end else begin
				row_i = $urandom_range(1, 12);
				frame_i = row_i * $urandom_range(1, 8) + $urandom_range(row_i - 1);
				count = frame_i * $urandom_range(1, 2) + $urandom_range(row_i);
				if (phase == 1 || phase == 3)
					count = STEADY_ITEMS;
			end
			run_phase(row_i, frame_i, count, pat, $urandom_range(7) == 0,
				phase == 3 || $urandom_range(9) == 0);
			phase++;
		end
		steady_tx = 1'b0;
		steady_rx = 1'b0;

		if (fail_count == 0 && outstanding == 0)
			$display("integral_image_with_squares_unit test passed");
		else
			$display("integral_image_with_squares_unit test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/iis_pkg.sv
design/iis_if.sv
design/iis_line_mem.sv
design/iis_front.sv
design/iis_back.sv
design/integral_image_with_squares_unit.sv
test/iis_sum_checker.sv
test/tb_top.sv
